/* rtl/fjhg_pkg.sv */
// Shared types and constants for the feeder jam recovery / heat gate block.
// No dependencies; the other files, apart from fjhg_if, refer to this package by scoped names.

package fjhg_pkg;

	// switch position codes
	localparam logic [1:0] SW_UP   = 2'd0;
	localparam logic [1:0] SW_MID  = 2'd1;
	localparam logic [1:0] SW_DOWN = 2'd2;

	// feeder command codes
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_COOLDOWN_TICKS  = 2'd0;
	localparam logic [1:0] CFG_HEAT_LIMIT      = 2'd1;
	localparam logic [1:0] CFG_FEEDER_SPEED    = 2'd2;
	localparam logic [1:0] CFG_STILL_THRESHOLD = 2'd3;

	// register reset values
	localparam logic [13:0] RST_COOLDOWN_TICKS  = 14'd200;
	localparam logic [15:0] RST_HEAT_LIMIT      = 16'd250;
	localparam logic [14:0] RST_FEEDER_SPEED    = 15'd20;
	localparam logic [15:0] RST_STILL_THRESHOLD = 16'd503;

	// state reset values
	localparam logic [13:0]        RST_COOLDOWN_COUNT = 14'd10;
	localparam logic signed [31:0] RST_PRIOR_POS      = 32'sd6554;

	// sequence limits
	localparam logic [13:0] COOL_CEIL   = 14'd10000;
	localparam logic [2:0]  STILL_TICKS = 3'd3;
	localparam logic [6:0]  BACK_END    = 7'd50;
	localparam logic [6:0]  RECOVER_END = 7'd100;

	typedef struct packed {
		logic [13:0] cooldown_ticks;
		logic [15:0] heat_limit;
		logic [14:0] feeder_speed;
		logic [15:0] still_threshold;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        right_switch;
		logic [1:0]        left_switch;
		logic              aim_lock;
		logic [15:0]       heat;
		logic signed [31:0] motor_pos;
	} sensor_t;

	// feeder sequencer result for one tick
	typedef struct packed {
		logic [1:0] dir;
		logic       jam;
	} jam_out_t;

endpackage

/* rtl/fjhg_if.sv */
// Valid/ready channel interfaces: sensor beats in, drive commands out.
// Standalone; no package dependency.

interface fjhg_sensor_if;
	logic               valid;
	logic               ready;
	logic [1:0]         right_switch;
	logic [1:0]         left_switch;
	logic               aim_lock;
	logic [15:0]        heat;
	logic signed [31:0] motor_pos;

	modport source(output valid, right_switch, left_switch, aim_lock, heat, motor_pos,
		input ready);
	modport sink(input valid, right_switch, left_switch, aim_lock, heat, motor_pos,
		output ready);
endinterface

interface fjhg_drive_if;
	logic               valid;
	logic               ready;
	logic [1:0]         feed_dir;
	logic signed [15:0] feeder_speed_cmd;
	logic               fire_enabled;
	logic               jam_active;

	modport source(output valid, feed_dir, feeder_speed_cmd, fire_enabled, jam_active,
		input ready);
	modport sink(input valid, feed_dir, feeder_speed_cmd, fire_enabled, jam_active,
		output ready);
endinterface

/* rtl/feeder_jam_recovery_heat_gate.sv */
// Top level: config registers, input stage, fire gate, jam sequencer, result register.
// Depends on fjhg_pkg, fjhg_if, fjhg_fire_gate, fjhg_jam_seq.
//
//  channel  dir  handshake      payload
//  sensor   in   valid/ready    right_switch, left_switch, aim_lock, heat, motor_pos
//  drive    out  valid/ready    feed_dir, feeder_speed_cmd, fire_enabled, jam_active
//  cfg      in   cfg_we         cfg_index, cfg_data
//
// One beat per cycle while drive is not stalled; a sensor beat accepted on
// sensor passes through the input register, then the result register, and
// leaves on drive from there. State updates as the beat moves from
// the input register into the result register. While drive is stalled the input
// register still takes one more beat. Reset is asynchronous, active low, and
// loads the register defaults and the initial tick state.

module feeder_jam_recovery_heat_gate (
	input  logic                 clk,
	input  logic                 arst_n,
	fjhg_sensor_if.sink          sensor,
	fjhg_drive_if.source         drive,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	fjhg_pkg::cfg_t     cfg_q;
	fjhg_pkg::sensor_t  item_s1;
	logic               valid_s1;
	logic               advance;
	logic               step;
	logic               fire;
	fjhg_pkg::jam_out_t jres;

	logic               out_valid_q;
	logic [1:0]         dir_q;
	logic signed [15:0] speed_q;
	logic               fire_q;
	logic               jam_q;
	logic signed [15:0] speed_n;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cooldown_ticks  <= fjhg_pkg::RST_COOLDOWN_TICKS;
			cfg_q.heat_limit      <= fjhg_pkg::RST_HEAT_LIMIT;
			cfg_q.feeder_speed    <= fjhg_pkg::RST_FEEDER_SPEED;
			cfg_q.still_threshold <= fjhg_pkg::RST_STILL_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				fjhg_pkg::CFG_COOLDOWN_TICKS:  cfg_q.cooldown_ticks  <= cfg_data[13:0];
				fjhg_pkg::CFG_HEAT_LIMIT:      cfg_q.heat_limit      <= cfg_data;
				fjhg_pkg::CFG_FEEDER_SPEED:    cfg_q.feeder_speed    <= cfg_data[14:0];
				fjhg_pkg::CFG_STILL_THRESHOLD: cfg_q.still_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign advance      = !out_valid_q || drive.ready;
	assign step         = valid_s1 && advance;
	assign sensor.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			item_s1.right_switch <= sensor.right_switch;
			item_s1.left_switch  <= sensor.left_switch;
			item_s1.aim_lock     <= sensor.aim_lock;
			item_s1.heat         <= sensor.heat;
			item_s1.motor_pos    <= sensor.motor_pos;
		end
	end

	fjhg_fire_gate u_fire_gate (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.fire   (fire)
	);

	fjhg_jam_seq u_jam_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.fire            (fire),
		.motor_pos       (item_s1.motor_pos),
		.still_threshold (cfg_q.still_threshold),
		.res             (jres)
	);

	// signed speed from the command
	always_comb begin
		case (jres.dir)
			fjhg_pkg::DIR_FWD: speed_n = $signed({1'b0, cfg_q.feeder_speed});
			fjhg_pkg::DIR_REV: speed_n = -$signed({1'b0, cfg_q.feeder_speed});
			default:           speed_n = '0;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			dir_q   <= jres.dir;
			speed_q <= speed_n;
			fire_q  <= fire;
			jam_q   <= jres.jam;
		end
	end

	assign drive.valid            = out_valid_q;
	assign drive.feed_dir         = dir_q;
	assign drive.feeder_speed_cmd = speed_q;
	assign drive.fire_enabled     = fire_q;
	assign drive.jam_active       = jam_q;

endmodule

/* rtl/fjhg_fire_gate.sv */
// Fire enable: mode switch decode and heat/cooldown gate, with its state.
// Depends on fjhg_pkg.

module fjhg_fire_gate (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  fjhg_pkg::sensor_t   item,
	input  fjhg_pkg::cfg_t      cfg,
	output logic                fire
);

	logic        fire_q;
	logic [13:0] cool_q;
	logic        fire_n;
	logic [13:0] cool_n;

	// mode decode, then the heat gate in priority order
	always_comb begin
		logic        gate;
		logic [13:0] c;
		gate   = 1'b0;
		fire_n = fire_q;
		cool_n = cool_q;
		c      = cool_q;
		case (item.right_switch)
			fjhg_pkg::SW_MID: begin
				fire_n = 1'b0;
			end
			fjhg_pkg::SW_DOWN: begin
				fire_n = (item.left_switch == fjhg_pkg::SW_DOWN);
				gate   = 1'b1;
			end
			fjhg_pkg::SW_UP: begin
				case (item.left_switch)
					fjhg_pkg::SW_DOWN, fjhg_pkg::SW_MID: begin
						fire_n = 1'b0;
					end
					fjhg_pkg::SW_UP: begin
						fire_n = item.aim_lock;
						gate   = 1'b1;
					end
					default: ; // unused code: hold
				endcase
			end
			default: ; // unused code: hold
		endcase

		if (gate) begin
			if (item.heat > cfg.heat_limit) begin
				fire_n = 1'b0;
				c      = '0;
			end
			if (item.heat == 16'd0)
				c = cfg.cooldown_ticks;
			if (c < cfg.cooldown_ticks) begin
				fire_n = 1'b0;
				c      = c + 14'd1;
			end else if (c > fjhg_pkg::COOL_CEIL) begin
				c = cfg.cooldown_ticks;
			end
			cool_n = c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_q <= 1'b0;
			cool_q <= fjhg_pkg::RST_COOLDOWN_COUNT;
		end else if (step) begin
			fire_q <= fire_n;
			cool_q <= cool_n;
		end
	end

	assign fire = fire_n;

endmodule

/* rtl/fjhg_jam_seq.sv */
// Feeder command and jam recovery sequencer with stall detection.
// Depends on fjhg_pkg.

module fjhg_jam_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 fire,
	input  logic signed [31:0]   motor_pos,
	input  logic [15:0]          still_threshold,
	output fjhg_pkg::jam_out_t   res
);

	logic               jam_q;
	logic [6:0]         rec_q;
	logic [2:0]         still_q;
	logic signed [31:0] prior_q;
	logic [1:0]         held_q;

	logic               jam_n;
	logic [6:0]         rec_n;
	logic [2:0]         still_n;
	logic [1:0]         dir;

	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic               stalled;

	// exact 33-bit position step and its magnitude
	assign diff    = {motor_pos[31], motor_pos} - {prior_q[31], prior_q};
	assign mag     = diff[32] ? 33'(-diff) : 33'(diff);
	assign stalled = (mag < {17'd0, still_threshold});

	always_comb begin
		logic [6:0] r;
		logic [2:0] s;
		dir     = fjhg_pkg::DIR_STOP;
		jam_n   = jam_q;
		rec_n   = rec_q;
		still_n = still_q;
		r       = rec_q + 7'd1;
		s       = still_q + 3'd1;
		if (fire) begin
			// recovery step
			if (!jam_q) begin
				dir = fjhg_pkg::DIR_FWD;
			end else if (r < fjhg_pkg::BACK_END) begin
				dir   = fjhg_pkg::DIR_REV;
				rec_n = r;
			end else if (r < fjhg_pkg::RECOVER_END) begin
				dir   = fjhg_pkg::DIR_FWD;
				rec_n = r;
			end else begin
				// recovery done: repeat last command
				dir   = held_q;
				rec_n = '0;
				jam_n = 1'b0;
			end
			// stall check against the post-recovery jam flag
			if (stalled && !jam_n) begin
				if (s > fjhg_pkg::STILL_TICKS) begin
					jam_n   = 1'b1;
					still_n = '0;
				end else begin
					still_n = s;
				end
			end else begin
				still_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jam_q   <= 1'b0;
			rec_q   <= '0;
			still_q <= '0;
			prior_q <= fjhg_pkg::RST_PRIOR_POS;
			held_q  <= fjhg_pkg::DIR_STOP;
		end else if (step) begin
			jam_q   <= jam_n;
			rec_q   <= rec_n;
			still_q <= still_n;
			prior_q <= motor_pos;
			held_q  <= dir;
		end
	end

	assign res.dir = dir;
	assign res.jam = jam_n;

endmodule
